// ----- sv/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define PLK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("plk check failed");

// clocked check that also holds through reset
`define PLK_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("plk check failed");

`endif

// ----- sv/plk_pkg.sv -----
package plk_pkg;

    // default list depth
    localparam int DEPTH_DEF = 16;
    // widest cell index over the supported depth range
    localparam int IDX_W_MAX = 8;

    localparam int OP_W      = 3;
    localparam int POS_W     = 9;
    localparam int ITEM_W    = 32;
    localparam int CNT_OUT_W = 5;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_GET    = 3'd3,
        OP_CLEAR  = 3'd4
    } t_plk_op;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic                 ins;
        logic                 rem;
        logic                 get;
        logic [IDX_W_MAX-1:0] idx;
    } t_plk_ctl;

endpackage

// ----- sv/plk_cell.sv -----
module plk_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                         i_clk,
    input  plk_pkg::t_plk_ctl            i_ctl,
    input  logic [plk_pkg::ITEM_W-1:0]   i_item,
    input  logic [plk_pkg::ITEM_W-1:0]   i_left,
    input  logic [plk_pkg::ITEM_W-1:0]   i_right,
    output logic [plk_pkg::ITEM_W-1:0]   o_data,
    output logic [plk_pkg::ITEM_W-1:0]   o_rd
);

    localparam logic [plk_pkg::IDX_W_MAX:0] K = CELL_IDX[plk_pkg::IDX_W_MAX:0];

    logic [plk_pkg::ITEM_W-1:0]    r_data;
    logic [plk_pkg::ITEM_W-1:0]    n_data;
    logic [plk_pkg::IDX_W_MAX:0]   w_idx;

    assign w_idx = {1'b0, i_ctl.idx};

    // shift up past the insert point, load at it, shift down from the remove point
    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && (K > w_idx)) begin
            n_data = i_left;
        end else if (i_ctl.ins && (K == w_idx)) begin
            n_data = i_item;
        end else if (i_ctl.rem && (K >= w_idx)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // read ports: o_data always shows the entry, o_rd is zero unless a get addresses this cell
    assign o_data = r_data;
    assign o_rd   = (i_ctl.get && (K == w_idx)) ? r_data : '0;

endmodule

// ----- sv/plk_ctrl.sv -----
module plk_ctrl #(
    parameter int DEPTH = plk_pkg::DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_fire,
    input  logic [plk_pkg::OP_W-1:0]           i_op,
    input  logic signed [plk_pkg::POS_W-1:0]   i_position,
    output plk_pkg::t_plk_ctl                  o_ctl,
    output logic                               o_ok,
    output logic [$clog2(DEPTH+1)-1:0]         o_count,
    output logic [$clog2(DEPTH+1)-1:0]         o_count_next
);

    localparam int CW = $clog2(DEPTH+1);
    localparam int IW = plk_pkg::IDX_W_MAX;

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic signed [9:0]       w_pos;
    logic signed [9:0]       w_n;
    logic                    w_full;
    logic                    w_empty;
    plk_pkg::t_plk_ctl       w_ctl;
    logic                    w_ok;

    assign w_pos   = 10'(i_position);
    assign w_n     = signed'(10'(r_count));
    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // decode the operation and clamp the position for insert and remove
    always_comb begin
        w_ctl   = '0;
        w_ok    = 1'b0;
        n_count = r_count;
        unique case (plk_pkg::t_plk_op'(i_op))
            plk_pkg::OP_APPEND: begin
                w_ctl.idx = IW'(r_count);
                if (!w_full) begin
                    w_ctl.ins = 1'b1;
                    w_ok      = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            plk_pkg::OP_INSERT: begin
                if (w_pos >= w_n) begin
                    w_ctl.idx = IW'(r_count);
                end else if (w_pos <= 0) begin
                    w_ctl.idx = '0;
                end else begin
                    w_ctl.idx = IW'(w_pos);
                end
                if (!w_full) begin
                    w_ctl.ins = 1'b1;
                    w_ok      = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            plk_pkg::OP_REMOVE: begin
                if (w_pos >= w_n - 10'sd1) begin
                    w_ctl.idx = IW'(r_count - 1'b1);
                end else if (w_pos <= 0) begin
                    w_ctl.idx = '0;
                end else begin
                    w_ctl.idx = IW'(w_pos);
                end
                if (!w_empty) begin
                    w_ctl.rem = 1'b1;
                    w_ok      = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            plk_pkg::OP_GET: begin
                w_ctl.idx = IW'(w_pos);
                if ((w_pos >= 0) && (w_pos < w_n)) begin
                    w_ctl.get = 1'b1;
                    w_ok      = 1'b1;
                end
            end
            plk_pkg::OP_CLEAR: begin
                w_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    // entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    // commands reach the cells only on a transfer
    assign o_ctl        = i_fire ? w_ctl : '0;
    assign o_ok         = w_ok;
    assign o_count      = r_count;
    assign o_count_next = n_count;

endmodule

// ----- sv/positional_list_store.sv -----
// Ordered list of up to DEPTH 32-bit handles, one operation per input transfer
// (append, insert, remove, get, clear) and one result transfer per operation.
// The entries sit in a row of cells, and an insert or remove shifts the
// entries past the affected position one cell over in the same cycle,
// while get reads the addressed cell. A new operation is taken every cycle as
// long as the result register is empty or its result is taken in that cycle.
// No clearing is needed after reset; entries past the count are never read.

`include "assert_macros.svh"

module positional_list_store #(
    parameter int DEPTH = plk_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [plk_pkg::OP_W-1:0]             i_op,
    input  logic signed [plk_pkg::POS_W-1:0]     i_position,
    input  logic [plk_pkg::ITEM_W-1:0]           i_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_ok,
    output logic [plk_pkg::ITEM_W-1:0]           o_read_item,
    output logic [plk_pkg::CNT_OUT_W-1:0]        o_entry_count
);

    localparam int CW = $clog2(DEPTH+1);

    logic                                w_fire;
    plk_pkg::t_plk_ctl                   w_ctl;
    logic                                w_ok;
    logic [CW-1:0]                       w_count;
    logic [CW-1:0]                       w_count_next;
    logic [CW+plk_pkg::CNT_OUT_W-1:0]    w_count_wide;
    logic [plk_pkg::ITEM_W-1:0]          w_data [DEPTH];
    logic [plk_pkg::ITEM_W-1:0]          w_rd   [DEPTH];
    logic [plk_pkg::ITEM_W-1:0]          w_rd_any;

    logic                                r_out_valid;
    logic                                r_ok;
    logic [plk_pkg::ITEM_W-1:0]          r_rd;
    logic [plk_pkg::CNT_OUT_W-1:0]       r_cnt;

    // input transfer whenever the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;

    plk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_op         (i_op),
        .i_position   (i_position),
        .o_ctl        (w_ctl),
        .o_ok         (w_ok),
        .o_count      (w_count),
        .o_count_next (w_count_next)
    );

    // row of entry cells, each wired to both neighbors, the end cells to themselves on the open side
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [plk_pkg::ITEM_W-1:0] w_left;
        logic [plk_pkg::ITEM_W-1:0] w_right;

        if (k == 0) begin : g_first
            assign w_left = w_data[k];
        end else begin : g_left
            assign w_left = w_data[k-1];
        end

        if (k == DEPTH-1) begin : g_last
            assign w_right = w_data[k];
        end else begin : g_right
            assign w_right = w_data[k+1];
        end

        plk_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_item  (i_item),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k]),
            .o_rd    (w_rd[k])
        );
    end

    // merge the cell read ports, at most one is nonzero
    always_comb begin
        w_rd_any = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_any = w_rd_any | w_rd[k];
        end
    end

    // count reported in five bits
    assign w_count_wide = {{plk_pkg::CNT_OUT_W{1'b0}}, w_count_next};

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_ok  <= w_ok;
            r_rd  <= w_rd_any;
            r_cnt <= w_count_wide[plk_pkg::CNT_OUT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_read_item   = r_rd;
    assign o_entry_count = r_cnt;

    // checks
    `PLK_ASSERT(a_count_bound, i_clk, i_rst_n, w_count <= CW'(DEPTH))
    `PLK_ASSERT(a_fire_gives_result, i_clk, i_rst_n, w_fire |=> o_out_valid)
    `PLK_ASSERT(a_fail_reads_zero, i_clk, i_rst_n, (o_out_valid && !o_ok) |-> (o_read_item == '0))
    `PLK_ASSERT(a_clear_empties, i_clk, i_rst_n, (w_fire && (i_op == plk_pkg::OP_CLEAR)) |=> (w_count == '0))

endmodule
